// ===== rtl/pc_pkg.sv =====
package pc_pkg;

   localparam int TABLE_DEPTH = 32768;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);
   localparam int CTX_SHIFT   = 7;
   localparam int GROUP_SIZE  = 8;
   localparam int GRP_IW      = $clog2(GROUP_SIZE);
   localparam int GRP_CW      = GRP_IW + 1;

   localparam logic [7:0]  SPACE_BYTE  = 8'h20;
   localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

   // one finished group handed from the predictor to the emitter
   typedef struct packed {
      logic [7:0]                       mask;
      logic [GROUP_SIZE-1:0][7:0]       lits;
      logic [GRP_CW-1:0]                count;
      logic                             last;
   } grp_type;

endpackage

// ===== rtl/pc_req_if.sv =====
interface pc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       is_last;

   modport source (output valid, output data_byte, output is_last, input ready);
   modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

// ===== rtl/pc_rsp_if.sv =====
interface pc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_mask;
   logic       last_of_run;
   logic       overflow;

   modport source (output valid, output out_byte, output is_mask, output last_of_run,
                   output overflow, input ready);
   modport sink (input valid, input out_byte, input is_mask, input last_of_run,
                 input overflow, output ready);
endinterface

// ===== rtl/pc_ram.sv =====
module pc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read colliding with a write returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pc_emit.sv =====
module pc_emit (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [31:0]     csr_wdata,
   input  logic            push,
   input  pc_pkg::grp_type grp,
   output logic            busy,
   pc_rsp_if.source        rsp
);
   import pc_pkg::*;

   logic [31:0]       limit_ff, limit_in;
   logic [31:0]       count_ff, count_in;
   logic              aborted_ff, aborted_in;
   logic              eb_valid_ff, eb_valid_in;
   grp_type           eb_ff, eb_in;
   logic [GRP_CW-1:0] pos_ff, pos_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_mask_ff, out_mask_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              out_free;
   logic              step;
   logic              run_end;
   logic [GRP_IW-1:0] lit_sel;

   assign out_free = !out_valid_ff || rsp.ready;
   assign step     = eb_valid_ff && (aborted_ff || out_free);
   assign run_end  = (pos_ff == eb_ff.count);
   assign lit_sel  = GRP_IW'(pos_ff - GRP_CW'(1));

   always_comb begin
      limit_in     = csr_we ? csr_wdata : limit_ff;
      count_in     = count_ff;
      aborted_in   = aborted_ff;
      eb_valid_in  = eb_valid_ff;
      eb_in        = eb_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_byte_in  = out_byte_ff;
      out_mask_in  = out_mask_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      if (push) begin
         eb_valid_in = 1'b1;
         eb_in       = grp;
         pos_in      = '0;
      end

      if (step) begin
         if (aborted_ff) begin
            // drop the whole group; a stream end re-arms
            eb_valid_in = 1'b0;
            pos_in      = '0;
            if (eb_ff.last) begin
               aborted_in = 1'b0;
               count_in   = '0;
            end
         end else if (count_ff >= limit_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = '0;
            out_mask_in  = 1'b0;
            out_last_in  = 1'b1;
            out_ovf_in   = 1'b1;
            eb_valid_in  = 1'b0;
            pos_in       = '0;
            aborted_in   = !eb_ff.last;
            if (eb_ff.last) begin
               count_in = '0;
            end
         end else begin
            out_valid_in = 1'b1;
            out_byte_in  = (pos_ff == '0) ? eb_ff.mask : eb_ff.lits[lit_sel];
            out_mask_in  = (pos_ff == '0);
            out_last_in  = run_end;
            out_ovf_in   = 1'b0;
            count_in     = count_ff + 32'd1;
            if (run_end) begin
               eb_valid_in = 1'b0;
               pos_in      = '0;
               if (eb_ff.last) begin
                  count_in = '0;
               end
            end else begin
               pos_in = pos_ff + GRP_CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         count_ff     <= '0;
         aborted_ff   <= 1'b0;
         eb_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         count_ff     <= count_in;
         aborted_ff   <= aborted_in;
         eb_valid_ff  <= eb_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      eb_ff       <= eb_in;
      out_byte_ff <= out_byte_in;
      out_mask_ff <= out_mask_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign busy            = eb_valid_ff;
   assign rsp.valid       = out_valid_ff;
   assign rsp.out_byte    = out_byte_ff;
   assign rsp.is_mask     = out_mask_ff;
   assign rsp.last_of_run = out_last_ff;
   assign rsp.overflow    = out_ovf_ff;

   a_pos_in_group: assert property (@(posedge clock) disable iff (reset)
      eb_valid_ff |-> pos_ff <= eb_ff.count)
      else $error("emit position beyond group");

   a_ovf_sets_abort: assert property (@(posedge clock) disable iff (reset)
      step && !aborted_ff && count_ff >= limit_ff && !eb_ff.last |=> aborted_ff)
      else $error("overflow did not abort the stream");

   a_count_held_when_aborted: assert property (@(posedge clock) disable iff (reset)
      aborted_ff && !(step && eb_ff.last) |=> $stable(count_ff))
      else $error("output count moved while aborted");

endmodule

// ===== rtl/predictor_compressor.sv =====
// Order-2 predictive byte compressor. Each req transfer carries one byte; its
// prediction comes from a 32768-entry table addressed by (prev1<<7)^prev2,
// held in a single-port-write RAM with a registered read. A byte
// enters every cycle while its group is filling: the read is issued at the
// transfer and compared in the next cycle, with the previous miss forwarded.
// Each group of eight bytes (or the partial group at is_last) yields a mask
// and then its literals, one rsp transfer per cycle while rsp is ready, from
// a single group buffer, so a new group waits while the previous one is still
// draining. Table entries carry an EPOCH_W-bit stream tag, so ending a stream
// clears the table at once; after reset, and after every 2**EPOCH_W-1 streams,
// a sweep rewrites all 32768 table entries and req.ready stays low meanwhile.
// csr_wdata sets the output limit; write it only while the block is idle.
module predictor_compressor #(
   parameter int EPOCH_W = 6
) (
   input  logic        clock,
   input  logic        reset,
   pc_req_if.sink      req,
   pc_rsp_if.source    rsp,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import pc_pkg::*;

   localparam int RAM_W = 8 + EPOCH_W;

   logic                    clearing_ff, clearing_in;
   logic [TBL_AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [EPOCH_W-1:0]      epoch_ff, epoch_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_fresh_ff, s1_fresh_in;
   logic [7:0]              s1_byte_ff, s1_byte_in;
   logic                    s1_last_ff, s1_last_in;
   logic [TBL_AW-1:0]       s1_addr_ff, s1_addr_in;
   logic [7:0]              hold_ff;

   logic                    fwd_valid_ff, fwd_valid_in;
   logic [TBL_AW-1:0]       fwd_addr_ff, fwd_addr_in;
   logic [7:0]              fwd_data_ff, fwd_data_in;

   logic [7:0]              prev_one_ff, prev_one_in;
   logic [7:0]              prev_two_ff, prev_two_in;
   logic [GRP_IW-1:0]       gc_ff, gc_in;
   logic [7:0]              mask_ff, mask_in;
   logic [GROUP_SIZE-1:0][7:0] lit_ff, lit_in;
   logic [GRP_CW-1:0]       lc_ff, lc_in;

   logic                    accept;
   logic                    adv;
   logic                    flush;
   logic                    wrap;
   logic                    hit;
   logic [7:0]              pred;
   logic [7:0]              mask_new;
   logic [GROUP_SIZE-1:0][7:0] lits_new;
   logic [GRP_CW-1:0]       lc_new;
   logic [TBL_AW-1:0]       rd_addr;
   logic [RAM_W-1:0]        rd_data;
   logic                    wr_en;
   logic [TBL_AW-1:0]       wr_addr;
   logic [RAM_W-1:0]        wr_data;
   logic                    eb_busy;
   logic                    push;
   grp_type                 grp;

   // prediction for the byte in stage 1
   always_comb begin
      if (!s1_fresh_ff) begin
         pred = hold_ff;
      end else if (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) begin
         pred = fwd_data_ff;
      end else if (rd_data[8 +: EPOCH_W] == epoch_ff) begin
         pred = rd_data[7:0];
      end else begin
         pred = SPACE_BYTE;
      end
   end

   assign hit   = (pred == s1_byte_ff);
   assign flush = (gc_ff == GRP_IW'(GROUP_SIZE - 1)) || s1_last_ff;
   assign adv   = s1_valid_ff && (!flush || !eb_busy);
   assign wrap  = s1_valid_ff && s1_last_ff && (epoch_ff == '1);
   assign push  = adv && flush;

   assign req.ready = !clearing_ff && !wrap && (!s1_valid_ff || adv);
   assign accept    = req.valid && req.ready;

   always_comb begin
      prev_one_in = prev_one_ff;
      prev_two_in = prev_two_ff;
      if (adv) begin
         if (s1_last_ff) begin
            prev_one_in = '0;
            prev_two_in = '0;
         end else begin
            prev_one_in = prev_two_ff;
            prev_two_in = s1_byte_ff;
         end
      end
   end

   assign rd_addr = (TBL_AW'(prev_one_in) << CTX_SHIFT) ^ TBL_AW'(prev_two_in);

   always_comb begin
      mask_new = mask_ff | (hit ? (8'd1 << gc_ff) : 8'd0);
      lits_new = lit_ff;
      if (!hit) begin
         lits_new[lc_ff[GRP_IW-1:0]] = s1_byte_ff;
      end
      lc_new = lc_ff + GRP_CW'(!hit);
   end

   always_comb begin
      grp.mask  = mask_new;
      grp.lits  = lits_new;
      grp.count = lc_new;
      grp.last  = s1_last_ff;
   end

   always_comb begin
      gc_in   = gc_ff;
      mask_in = mask_ff;
      lit_in  = lit_ff;
      lc_in   = lc_ff;
      if (adv) begin
         lit_in = lits_new;
         if (flush) begin
            gc_in   = '0;
            mask_in = '0;
            lc_in   = '0;
         end else begin
            gc_in   = gc_ff + GRP_IW'(1);
            mask_in = mask_new;
            lc_in   = lc_new;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_fresh_in = 1'b0;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      s1_addr_in  = s1_addr_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_fresh_in = 1'b1;
         s1_byte_in  = req.data_byte;
         s1_last_in  = req.is_last;
         s1_addr_in  = rd_addr;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // remember the write issued alongside the next read
   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      if (adv) begin
         fwd_valid_in = !hit && !s1_last_ff;
         fwd_addr_in  = s1_addr_ff;
         fwd_data_in  = s1_byte_ff;
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      epoch_in    = epoch_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + TBL_AW'(1);
         if (clr_addr_ff == '1) begin
            clearing_in = 1'b0;
            epoch_in    = EPOCH_W'(1);
         end
      end else if (adv && s1_last_ff) begin
         if (epoch_ff == '1) begin
            clearing_in = 1'b1;
            clr_addr_in = '0;
         end else begin
            epoch_in = epoch_ff + EPOCH_W'(1);
         end
      end
   end

   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = {EPOCH_W'(0), SPACE_BYTE};
      end else begin
         wr_en   = adv && !hit;
         wr_addr = s1_addr_ff;
         wr_data = {epoch_ff, s1_byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         epoch_ff     <= EPOCH_W'(1);
         s1_valid_ff  <= 1'b0;
         s1_fresh_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         prev_one_ff  <= '0;
         prev_two_ff  <= '0;
         gc_ff        <= '0;
         mask_ff      <= '0;
         lc_ff        <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         epoch_ff     <= epoch_in;
         s1_valid_ff  <= s1_valid_in;
         s1_fresh_ff  <= s1_fresh_in;
         fwd_valid_ff <= fwd_valid_in;
         prev_one_ff  <= prev_one_in;
         prev_two_ff  <= prev_two_in;
         gc_ff        <= gc_in;
         mask_ff      <= mask_in;
         lc_ff        <= lc_in;
      end
      s1_byte_ff  <= s1_byte_in;
      s1_last_ff  <= s1_last_in;
      s1_addr_ff  <= s1_addr_in;
      hold_ff     <= pred;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      lit_ff      <= lit_in;
   end

   pc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push),
      .grp       (grp),
      .busy      (eb_busy),
      .rsp       (rsp)
   );

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !accept)
      else $error("transfer accepted during table sweep");

   a_push_into_free: assert property (@(posedge clock) disable iff (reset)
      push |-> !eb_busy)
      else $error("group handed to a busy emitter");

   a_group_restart: assert property (@(posedge clock) disable iff (reset)
      push |=> gc_ff == '0 && lc_ff == '0 && mask_ff == '0)
      else $error("group state not cleared after flush");

   a_accept_loads_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff && s1_fresh_ff)
      else $error("accepted byte missing from stage 1");

endmodule
